/* rtl/etmwd_pkg.sv */
// Shared types, constants and helpers for the edge table min-weight dedup block.
// Used by etmwd_ctrl, etmwd_datapath and edge_table_min_weight_dedup.
// No dependencies.
package etmwd_pkg;

  // Table geometry: one row per smaller endpoint, one column per larger endpoint
  localparam int NUM_VTX  = 64;
  localparam int VTX_W    = $clog2(NUM_VTX);
  localparam int COL_W    = VTX_W + 1;          // column cursor, may sit one past the row
  localparam int TBL_AW   = 2 * VTX_W;
  localparam int WEIGHT_W = 32;
  localparam int COUNT_W  = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam int MAX_EDGES = NUM_VTX * (NUM_VTX - 1) / 2;
  localparam logic [VTX_W-1:0] LAST_ROW = '1;
  localparam logic [COL_W-1:0] ROW_END  = COL_W'(NUM_VTX);

  typedef logic [NUM_VTX-1:0] row_bits_t;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_FETCH  = 2'd1,
    MODE_REWIND = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_NEW      = 3'd0,
    ST_MERGED   = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_GIVEN    = 3'd3,
    ST_END      = 3'd4,
    ST_REWOUND  = 3'd5,
    ST_CLEARED  = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_WR,
    S_F_CHK,
    S_F_ROW,
    S_F_WT,
    S_RW_RD,
    S_RW_LD,
    S_CLR,
    S_FIN
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;     // capture the input payload
    logic add_read;    // read bitmap row and weight of the added pair
    logic add_commit;  // insert or merge, set result
    logic fetch_take;  // take hit in cursor row, read its weight
    logic row_next;    // move cursor to next live row, read its bitmap
    logic load_row;    // load cursor row bitmap from read data
    logic fetch_give;  // set result for a given edge
    logic fetch_end;   // set result for end of scan, park cursor
    logic rewind;      // cursor to origin, read row 0
    logic rewound;     // set rewind result
    logic clear;       // empty the table, set clear result
    logic finish;      // load the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cur_hit;     // stored edge at or after cursor in cursor row
    logic next_found;  // a live row lies after the cursor row
    logic out_free;    // output register can take a result
  } stat_t;

  typedef struct packed {
    logic             found;
    logic [VTX_W-1:0] idx;
  } ffs_t;

  // Lowest set bit of a row
  function automatic ffs_t find_first(input row_bits_t bits);
    ffs_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int i = NUM_VTX - 1; i >= 0; i--) begin
      if (bits[i]) begin
        r.found = 1'b1;
        r.idx   = VTX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

/* rtl/etmwd_ctrl.sv */
// Controller state machine for the edge table min-weight dedup block.
// Sequences add, fetch, rewind and clear items; depends on etmwd_pkg.
module etmwd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          mode,
  input  etmwd_pkg::stat_t    stat,
  output logic                in_ready,
  output etmwd_pkg::cmd_t     cmd
);

  etmwd_pkg::state_t state, state_next;
  etmwd_pkg::mode_t  mode_in;

  assign mode_in = etmwd_pkg::mode_t'(mode);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= etmwd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      etmwd_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (mode_in)
            etmwd_pkg::MODE_ADD:    state_next = etmwd_pkg::S_ADD_RD;
            etmwd_pkg::MODE_FETCH:  state_next = etmwd_pkg::S_F_CHK;
            etmwd_pkg::MODE_REWIND: state_next = etmwd_pkg::S_RW_RD;
            etmwd_pkg::MODE_CLEAR:  state_next = etmwd_pkg::S_CLR;
            default:                state_next = etmwd_pkg::S_IDLE;
          endcase
        end
      end
      etmwd_pkg::S_ADD_RD: state_next = etmwd_pkg::S_ADD_WR;
      etmwd_pkg::S_ADD_WR: state_next = etmwd_pkg::S_FIN;
      etmwd_pkg::S_F_CHK: begin
        priority if (stat.cur_hit) begin
          state_next = etmwd_pkg::S_F_WT;
        end else if (stat.next_found) begin
          state_next = etmwd_pkg::S_F_ROW;
        end else begin
          state_next = etmwd_pkg::S_FIN;
        end
      end
      etmwd_pkg::S_F_ROW:  state_next = etmwd_pkg::S_F_CHK;
      etmwd_pkg::S_F_WT:   state_next = etmwd_pkg::S_FIN;
      etmwd_pkg::S_RW_RD:  state_next = etmwd_pkg::S_RW_LD;
      etmwd_pkg::S_RW_LD:  state_next = etmwd_pkg::S_FIN;
      etmwd_pkg::S_CLR:    state_next = etmwd_pkg::S_FIN;
      etmwd_pkg::S_FIN: begin
        if (stat.out_free) state_next = etmwd_pkg::S_IDLE;
      end
      default: state_next = etmwd_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      etmwd_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      etmwd_pkg::S_ADD_RD: cmd.add_read   = 1'b1;
      etmwd_pkg::S_ADD_WR: cmd.add_commit = 1'b1;
      etmwd_pkg::S_F_CHK: begin
        priority if (stat.cur_hit) begin
          cmd.fetch_take = 1'b1;
        end else if (stat.next_found) begin
          cmd.row_next = 1'b1;
        end else begin
          cmd.fetch_end = 1'b1;
        end
      end
      etmwd_pkg::S_F_ROW: cmd.load_row   = 1'b1;
      etmwd_pkg::S_F_WT:  cmd.fetch_give = 1'b1;
      etmwd_pkg::S_RW_RD: cmd.rewind     = 1'b1;
      etmwd_pkg::S_RW_LD: begin
        cmd.load_row = 1'b1;
        cmd.rewound  = 1'b1;
      end
      etmwd_pkg::S_CLR: cmd.clear  = 1'b1;
      etmwd_pkg::S_FIN: cmd.finish = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

/* rtl/etmwd_datapath.sv */
// Datapath for the edge table min-weight dedup block: bitmap and weight
// memories, row live bits, scan cursor, edge count and output register.
// Depends on etmwd_pkg.
module etmwd_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  etmwd_pkg::cmd_t                       cmd,
  input  logic [etmwd_pkg::VTX_W-1:0]           vertex_a,
  input  logic [etmwd_pkg::VTX_W-1:0]           vertex_b,
  input  logic signed [etmwd_pkg::WEIGHT_W-1:0] weight,
  input  logic                                  out_ready,
  output etmwd_pkg::stat_t                      stat,
  output logic                                  out_valid,
  output logic [2:0]                            status,
  output logic [etmwd_pkg::VTX_W-1:0]           edge_low,
  output logic [etmwd_pkg::VTX_W-1:0]           edge_high,
  output logic signed [etmwd_pkg::WEIGHT_W-1:0] edge_weight,
  output logic [etmwd_pkg::COUNT_W-1:0]         edge_count,
  output logic                                  scan_done
);

  // Memories: one bitmap row per smaller endpoint, one weight per pair
  etmwd_pkg::row_bits_t               bmap_mem [etmwd_pkg::NUM_VTX];
  logic [etmwd_pkg::WEIGHT_W-1:0]     wt_mem   [2**etmwd_pkg::TBL_AW];

  etmwd_pkg::row_bits_t               bmap_rdata, bmap_wdata;
  logic [etmwd_pkg::VTX_W-1:0]        bmap_raddr;
  logic                               bmap_re, bmap_we;
  logic signed [etmwd_pkg::WEIGHT_W-1:0] wt_rdata;
  logic [etmwd_pkg::TBL_AW-1:0]       wt_raddr;
  logic                               wt_re, wt_we;

  // Control state
  etmwd_pkg::row_bits_t               live, live_next;
  etmwd_pkg::row_bits_t               cur_bits, cur_bits_next;
  logic [etmwd_pkg::VTX_W-1:0]        crow, crow_next;
  logic [etmwd_pkg::COL_W-1:0]        ccol, ccol_next;
  logic [etmwd_pkg::COUNT_W-1:0]      count, count_next;
  logic                               out_valid_next;

  // Payload registers
  logic [etmwd_pkg::VTX_W-1:0]        va, vb;
  logic signed [etmwd_pkg::WEIGHT_W-1:0] w_in;
  logic [etmwd_pkg::VTX_W-1:0]        hit_col;
  etmwd_pkg::status_t                 res_status;
  logic [etmwd_pkg::VTX_W-1:0]        res_low, res_high;
  logic signed [etmwd_pkg::WEIGHT_W-1:0] res_weight;

  // Add-path values
  logic [etmwd_pkg::VTX_W-1:0]        lo, hi;
  logic                               is_loop, present;
  etmwd_pkg::row_bits_t               row_read;
  logic                               w_less;

  // Scan search
  etmwd_pkg::row_bits_t               cur_masked, rows_after;
  etmwd_pkg::ffs_t                    col_hit, row_hit;

  assign lo      = (va < vb) ? va : vb;
  assign hi      = (va < vb) ? vb : va;
  assign is_loop = (va == vb);
  // Rows never touched since reset or clear read as empty
  assign row_read = live[lo] ? bmap_rdata : '0;
  assign present  = row_read[hi];
  assign w_less   = (w_in < wt_rdata);

  assign cur_masked = cur_bits & ({etmwd_pkg::NUM_VTX{1'b1}} << ccol);
  assign rows_after = live & ({etmwd_pkg::NUM_VTX{1'b1}} << ({1'b0, crow} + 7'd1));
  assign col_hit    = etmwd_pkg::find_first(cur_masked);
  assign row_hit    = etmwd_pkg::find_first(rows_after);

  assign stat.cur_hit    = col_hit.found;
  assign stat.next_found = row_hit.found;
  assign stat.out_free   = !out_valid || out_ready;

  // Memory read and write controls
  always_comb begin
    bmap_re    = cmd.add_read || cmd.row_next || cmd.rewind;
    bmap_raddr = '0;
    priority if (cmd.add_read) begin
      bmap_raddr = lo;
    end else if (cmd.row_next) begin
      bmap_raddr = row_hit.idx;
    end else begin
      bmap_raddr = '0;
    end
    wt_re    = cmd.add_read || cmd.fetch_take;
    wt_raddr = cmd.add_read ? {lo, hi} : {crow, col_hit.idx};
    bmap_we    = cmd.add_commit && !is_loop && !present;
    bmap_wdata = row_read | (etmwd_pkg::row_bits_t'(1) << hi);
    wt_we      = cmd.add_commit && !is_loop && (!present || w_less);
  end

  always_ff @(posedge clk) begin
    if (bmap_we) bmap_mem[lo] <= bmap_wdata;
    if (bmap_re) bmap_rdata <= bmap_mem[bmap_raddr];
  end

  always_ff @(posedge clk) begin
    if (wt_we) wt_mem[{lo, hi}] <= w_in;
    if (wt_re) wt_rdata <= wt_mem[wt_raddr];
  end

  // Next values of table, cursor and count
  always_comb begin
    live_next     = live;
    cur_bits_next = cur_bits;
    crow_next     = crow;
    ccol_next     = ccol;
    count_next    = count;
    if (cmd.add_commit && !is_loop && !present) begin
      live_next[lo] = 1'b1;
      if (count != etmwd_pkg::COUNT_MAX) count_next = count + 11'd1;
      if (lo == crow) cur_bits_next[hi] = 1'b1;
    end
    if (cmd.fetch_take) ccol_next = {1'b0, col_hit.idx} + 7'd1;
    if (cmd.row_next) begin
      crow_next = row_hit.idx;
      ccol_next = '0;
    end
    if (cmd.load_row) cur_bits_next = live[crow] ? bmap_rdata : '0;
    if (cmd.fetch_end) begin
      crow_next = etmwd_pkg::LAST_ROW;
      ccol_next = etmwd_pkg::ROW_END;
    end
    if (cmd.rewind) begin
      crow_next = '0;
      ccol_next = '0;
    end
    if (cmd.clear) begin
      live_next     = '0;
      cur_bits_next = '0;
      crow_next     = '0;
      ccol_next     = '0;
      count_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live     <= '0;
      cur_bits <= '0;
      crow     <= '0;
      ccol     <= '0;
      count    <= '0;
    end else begin
      live     <= live_next;
      cur_bits <= cur_bits_next;
      crow     <= crow_next;
      ccol     <= ccol_next;
      count    <= count_next;
    end
  end

  // Input capture, hit column and result fields
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      va   <= vertex_a;
      vb   <= vertex_b;
      w_in <= weight;
    end
    if (cmd.fetch_take) hit_col <= col_hit.idx;
    if (cmd.add_commit) begin
      priority if (is_loop) begin
        res_status <= etmwd_pkg::ST_DROPPED;
        res_low    <= va;
        res_high   <= va;
        res_weight <= '0;
      end else if (present) begin
        res_status <= etmwd_pkg::ST_MERGED;
        res_low    <= lo;
        res_high   <= hi;
        res_weight <= w_less ? w_in : wt_rdata;
      end else begin
        res_status <= etmwd_pkg::ST_NEW;
        res_low    <= lo;
        res_high   <= hi;
        res_weight <= w_in;
      end
    end
    if (cmd.fetch_give) begin
      res_status <= etmwd_pkg::ST_GIVEN;
      res_low    <= crow;
      res_high   <= hit_col;
      res_weight <= wt_rdata;
    end
    if (cmd.fetch_end || cmd.rewound || cmd.clear) begin
      priority if (cmd.fetch_end) begin
        res_status <= etmwd_pkg::ST_END;
      end else if (cmd.rewound) begin
        res_status <= etmwd_pkg::ST_REWOUND;
      end else begin
        res_status <= etmwd_pkg::ST_CLEARED;
      end
      res_low    <= '0;
      res_high   <= '0;
      res_weight <= '0;
    end
  end

  // Output register; scan_done reflects the cursor after this item
  assign out_valid_next = cmd.finish ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status      <= res_status;
      edge_low    <= res_low;
      edge_high   <= res_high;
      edge_weight <= res_weight;
      edge_count  <= count;
      scan_done   <= !(col_hit.found || row_hit.found);
    end
  end

endmodule

/* rtl/edge_table_min_weight_dedup.sv */
// Top level of the edge table min-weight dedup block.
// Instantiates etmwd_ctrl and etmwd_datapath; depends on etmwd_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries mode, vertex_a, vertex_b, weight.
//   Mode add stores a vertex pair or keeps the smaller weight, fetch returns the
//   next stored edge in row-then-column order, rewind restarts the scan, clear
//   empties the table. Every item gives exactly one result on the output
//   channel (out_valid/out_ready): status, endpoints, weight, edge count and
//   scan_done.
//   One item is in work at a time. After the input transfer, clear empties
//   the table; add reads the bitmap row and weight, then commits; rewind
//   reads row 0, then loads it; fetch checks the cursor row, steps first to
//   the next live row with one bitmap read when no hit lies there, then reads
//   the weight, or goes straight to its result when nothing is left. in_ready
//   returns the cycle after the result is loaded; the next item is taken even
//   while the previous result sits unclaimed in the output register.
//   Reset clears the row live bits, cursor and count at once; no clearing pass.
//   When the receiver stalls, the next result holds in its final step until
//   the output register is free.
module edge_table_min_weight_dedup (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            mode,
  input  logic [etmwd_pkg::VTX_W-1:0]           vertex_a,
  input  logic [etmwd_pkg::VTX_W-1:0]           vertex_b,
  input  logic signed [etmwd_pkg::WEIGHT_W-1:0] weight,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [2:0]                            status,
  output logic [etmwd_pkg::VTX_W-1:0]           edge_low,
  output logic [etmwd_pkg::VTX_W-1:0]           edge_high,
  output logic signed [etmwd_pkg::WEIGHT_W-1:0] edge_weight,
  output logic [etmwd_pkg::COUNT_W-1:0]         edge_count,
  output logic                                  scan_done
);

  etmwd_pkg::cmd_t  cmd;
  etmwd_pkg::stat_t stat;

  etmwd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  etmwd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .vertex_a    (vertex_a),
    .vertex_b    (vertex_b),
    .weight      (weight),
    .out_ready   (out_ready),
    .stat        (stat),
    .out_valid   (out_valid),
    .status      (status),
    .edge_low    (edge_low),
    .edge_high   (edge_high),
    .edge_weight (edge_weight),
    .edge_count  (edge_count),
    .scan_done   (scan_done)
  );

`ifndef NO_ASSERTIONS
  // One item at a time: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in work");

  // Count never exceeds the number of possible pairs
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (edge_count <= 11'(etmwd_pkg::MAX_EDGES)))
    else $error("edge count beyond pair limit");

  // A given edge is always smaller endpoint first
  a_given_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == etmwd_pkg::ST_GIVEN) |-> (edge_low < edge_high))
    else $error("given edge not ordered");

  // End of scan always reports scan done
  a_end_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == etmwd_pkg::ST_END) |-> scan_done)
    else $error("end of scan without scan_done");
`endif

endmodule
